// ----- rtl/core/binary_pixel_linear_classifier_unit_assert.svh -----
// assertion macros for the binary pixel linear classifier
// expects signals clk and arst_n in the scope of each use
`ifndef BINARY_PIXEL_LINEAR_CLASSIFIER_UNIT_ASSERT_SVH
`define BINARY_PIXEL_LINEAR_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define BPLC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bplc_pkg.sv -----
// shared constants, types and helpers of the binary pixel linear classifier
// no dependencies
package bplc_pkg;

	localparam int NUM_FEATURES = 784;
	localparam int NUM_CLASSES  = 10;
	localparam int WEIGHT_BITS  = 16;

	// fixed port field widths
	localparam int FEATURE_IDX_W = 10;
	localparam int CLASS_IDX_W   = 4;
	localparam int WEIGHT_IN_W   = 16;
	localparam int PIXEL_W       = 8;
	localparam int LABEL_W       = 4;
	localparam int SUM_W         = 26;
	localparam int ERR_W         = 32;

	localparam int FEAT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int CLS_W  = $clog2(NUM_CLASSES);
	localparam int ADD_W  = ((SUM_W > WEIGHT_BITS) ? SUM_W : WEIGHT_BITS) + 1;

	// command queue, depth a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [FEAT_W-1:0]             feat_t;
	typedef logic [CLS_W-1:0]              cls_t;
	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic signed [ADD_W-1:0]       add_t;
	typedef logic [QPTR_W-1:0]             qptr_t;
	typedef logic [QCNT_W-1:0]             qcnt_t;
	typedef logic [ERR_W-1:0]              err_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam err_t ERR_MAX = {ERR_W{1'b1}};

	// decoded word handed from front to back
	typedef struct packed {
		logic                 wr;
		logic                 add;
		logic                 last;
		feat_t                feat;
		cls_t                 cls;
		weight_t              weight;
		logic [LABEL_W-1:0]   label;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_SCAN,
		BK_EMIT
	} bk_state_t;

	// saturating accumulate of one weight into a class sum
	function automatic sum_t sat_add(sum_t s, weight_t w);
		add_t a;
		a = add_t'(s) + add_t'(w);
		if (a > add_t'(SUM_MAX)) begin
			return SUM_MAX;
		end else if (a < add_t'(SUM_MIN)) begin
			return SUM_MIN;
		end
		return sum_t'(a);
	endfunction

endpackage

// ----- rtl/core/bplc_front.sv -----
// front end: accepts input words and decodes them into queue commands
// depends on bplc_pkg
module bplc_front (
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [bplc_pkg::FEATURE_IDX_W-1:0]  feature_index,
	input  logic [bplc_pkg::CLASS_IDX_W-1:0]    class_index,
	input  logic signed [bplc_pkg::WEIGHT_IN_W-1:0] weight_value,
	input  logic [bplc_pkg::PIXEL_W-1:0]        pixel_value,
	input  logic [bplc_pkg::LABEL_W-1:0]        true_label,
	input  logic                                last_pixel,
	input  logic                                q_full,
	output logic                                q_push,
	output bplc_pkg::cmd_t                      q_cmd
);

	logic feat_ok;
	logic cls_ok;

	assign feat_ok = 32'(feature_index) < 32'(bplc_pkg::NUM_FEATURES);
	assign cls_ok  = 32'(class_index) < 32'(bplc_pkg::NUM_CLASSES);

	always_comb begin
		q_cmd.wr     = !req_type && feat_ok && cls_ok;
		q_cmd.add    = req_type && (pixel_value != '0) && feat_ok;
		q_cmd.last   = req_type && last_pixel;
		q_cmd.feat   = bplc_pkg::feat_t'(feature_index);
		q_cmd.cls    = bplc_pkg::cls_t'(class_index);
		q_cmd.weight = bplc_pkg::weight_t'(weight_value);
		q_cmd.label  = true_label;
	end

	// words with no effect are taken and dropped
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full && (q_cmd.wr || q_cmd.add || q_cmd.last);

endmodule

// ----- rtl/core/bplc_queue.sv -----
// short command queue between front and back end
// depends on bplc_pkg
module bplc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bplc_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output bplc_pkg::cmd_t pop_cmd
);

	bplc_pkg::cmd_t  entries_q [bplc_pkg::QUEUE_DEPTH];
	bplc_pkg::qptr_t wr_ptr_q;
	bplc_pkg::qptr_t rd_ptr_q;
	bplc_pkg::qcnt_t count_q;

	assign full      = count_q == bplc_pkg::qcnt_t'(bplc_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bplc_pkg::qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bplc_pkg::qptr_t'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bplc_pkg::qcnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bplc_pkg::qcnt_t'(1);
			end
		end
	end

endmodule

// ----- rtl/core/bplc_back.sv -----
// back end: weight store, class accumulators, argmax scan and result register
// depends on bplc_pkg
module bplc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  bplc_pkg::cmd_t                    q_cmd,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bplc_pkg::CLASS_IDX_W-1:0]  predicted_class,
	output logic signed [bplc_pkg::SUM_W-1:0] best_score,
	output logic                              mismatch,
	output logic [bplc_pkg::ERR_W-1:0]        error_count
);

	localparam bplc_pkg::cls_t LAST_CLS = bplc_pkg::cls_t'(bplc_pkg::NUM_CLASSES - 1);

	// weight store, one row of class weights per feature
	bplc_pkg::weight_t [bplc_pkg::NUM_CLASSES-1:0] mem_q [bplc_pkg::NUM_FEATURES];

	bplc_pkg::weight_t [bplc_pkg::NUM_CLASSES-1:0] row_s1;
	logic                        valid_s1;
	logic                        add_s1;
	logic                        last_s1;
	logic [bplc_pkg::LABEL_W-1:0] label_s1;

	bplc_pkg::sum_t   sums_q [bplc_pkg::NUM_CLASSES];
	bplc_pkg::bk_state_t state_q;
	bplc_pkg::bk_state_t state_d;
	bplc_pkg::cls_t   scan_idx_q;
	bplc_pkg::cls_t   best_idx_q;
	bplc_pkg::sum_t   best_val_q;
	logic [bplc_pkg::LABEL_W-1:0] label_q;
	bplc_pkg::err_t   err_q;
	logic             out_valid_q;
	logic [bplc_pkg::CLASS_IDX_W-1:0] class_q;
	bplc_pkg::sum_t   score_q;
	logic             miss_q;

	logic scan_en;
	logic emit_en;
	logic miss_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bplc_pkg::BK_RUN: begin
				if (valid_s1 && last_s1) begin
					state_d = bplc_pkg::BK_SCAN;
				end
			end
			bplc_pkg::BK_SCAN: begin
				if (scan_idx_q == LAST_CLS) begin
					state_d = bplc_pkg::BK_EMIT;
				end
			end
			bplc_pkg::BK_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = bplc_pkg::BK_RUN;
				end
			end
			default: state_d = bplc_pkg::BK_RUN;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop   = 1'b0;
		scan_en = 1'b0;
		emit_en = 1'b0;
		unique case (state_q)
			bplc_pkg::BK_RUN:  q_pop   = q_valid && !(valid_s1 && last_s1);
			bplc_pkg::BK_SCAN: scan_en = 1'b1;
			bplc_pkg::BK_EMIT: emit_en = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// store write and registered row read
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.wr) begin
			mem_q[q_cmd.feat][q_cmd.cls] <= q_cmd.weight;
		end
		if (q_pop && q_cmd.add) begin
			row_s1 <= mem_q[q_cmd.feat];
		end
		if (q_pop) begin
			add_s1   <= q_cmd.add;
			last_s1  <= q_cmd.last;
			label_s1 <= q_cmd.label;
		end
	end

	assign miss_d = label_q != bplc_pkg::LABEL_W'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bplc_pkg::BK_RUN;
			valid_s1    <= 1'b0;
			scan_idx_q  <= '0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < bplc_pkg::NUM_CLASSES; k++) begin
				sums_q[k] <= '0;
			end
		end else begin
			state_q  <= state_d;
			valid_s1 <= q_pop && (q_cmd.add || q_cmd.last);
			if (emit_en) begin
				for (int k = 0; k < bplc_pkg::NUM_CLASSES; k++) begin
					sums_q[k] <= '0;
				end
			end else if (valid_s1 && add_s1) begin
				for (int k = 0; k < bplc_pkg::NUM_CLASSES; k++) begin
					sums_q[k] <= bplc_pkg::sat_add(sums_q[k], row_s1[k]);
				end
			end
			if (scan_en) begin
				scan_idx_q <= (scan_idx_q == LAST_CLS) ? '0 : scan_idx_q + bplc_pkg::cls_t'(1);
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
				if (miss_d && err_q != bplc_pkg::ERR_MAX) begin
					err_q <= err_q + bplc_pkg::err_t'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// argmax scan, strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			label_q <= label_s1;
		end
		if (scan_en && (scan_idx_q == '0 || sums_q[scan_idx_q] > best_val_q)) begin
			best_idx_q <= scan_idx_q;
			best_val_q <= sums_q[scan_idx_q];
		end
		if (emit_en) begin
			class_q <= bplc_pkg::CLASS_IDX_W'(best_idx_q);
			score_q <= best_val_q;
			miss_q  <= miss_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign predicted_class = class_q;
	assign best_score      = score_q;
	assign mismatch        = miss_q;
	assign error_count     = err_q;

endmodule

// ----- rtl/core/binary_pixel_linear_classifier_unit.sv -----
// top level of the binary pixel linear classifier
// depends on bplc_pkg, bplc_front, bplc_queue, bplc_back and the assertion header
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready | req_type, feature_index, class_index,
//           |           |                     | weight_value, pixel_value, true_label, last_pixel
//   out     | output    | out_valid/out_ready | predicted_class, best_score, mismatch, error_count
//
// weight writes and pixels are taken one word per cycle while the command queue has room
// a last pixel holds the back end through the row read, the argmax scan over the class accumulators
// and the load of the result register, which waits while an earlier result is still stalled
// reset clears the accumulators, error count and queue; the weight store is not cleared
// a stalled result waits in the output register while further words keep accumulating
`include "binary_pixel_linear_classifier_unit_assert.svh"

module binary_pixel_linear_classifier_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    req_type,
	input  logic [bplc_pkg::FEATURE_IDX_W-1:0]      feature_index,
	input  logic [bplc_pkg::CLASS_IDX_W-1:0]        class_index,
	input  logic signed [bplc_pkg::WEIGHT_IN_W-1:0] weight_value,
	input  logic [bplc_pkg::PIXEL_W-1:0]            pixel_value,
	input  logic [bplc_pkg::LABEL_W-1:0]            true_label,
	input  logic                                    last_pixel,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [bplc_pkg::CLASS_IDX_W-1:0]        predicted_class,
	output logic signed [bplc_pkg::SUM_W-1:0]       best_score,
	output logic                                    mismatch,
	output logic [bplc_pkg::ERR_W-1:0]              error_count
);

	// decoded words between front and queue
	logic           q_push;
	logic           q_full;
	bplc_pkg::cmd_t push_cmd;

	// queue to back end
	logic           q_pop;
	logic           q_valid;
	bplc_pkg::cmd_t pop_cmd;

	// front end: binarize pixels, range-check indexes, drop words with no effect
	bplc_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.feature_index (feature_index),
		.class_index   (class_index),
		.weight_value  (weight_value),
		.pixel_value   (pixel_value),
		.true_label    (true_label),
		.last_pixel    (last_pixel),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	// decouples the input side from the back end during an argmax scan
	bplc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (pop_cmd)
	);

	// back end: store writes, row accumulate, scan and result register
	bplc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (pop_cmd),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.predicted_class (predicted_class),
		.best_score      (best_score),
		.mismatch        (mismatch),
		.error_count     (error_count)
	);

	// back end never pops an empty queue
	`BPLC_ASSERT_IMPLY(a_pop_has_word, q_pop, q_valid, "pop from empty command queue")
	// front never pushes into a full queue
	`BPLC_ASSERT_IMPLY(a_push_has_room, q_push, !q_full, "push into full command queue")
	// running error count never goes down
	`BPLC_ASSERT_NEXT(a_err_monotonic, arst_n, error_count >= $past(error_count), "error count decreased")
	// winning class is a real class
	`BPLC_ASSERT_IMPLY(a_class_range, out_valid, 32'(predicted_class) < 32'(bplc_pkg::NUM_CLASSES), "predicted class out of range")

endmodule

// ----- tb/tb_binary_pixel_linear_classifier_unit.sv -----
// self-checking testbench of the binary pixel linear classifier unit
// depends on bplc_pkg and binary_pixel_linear_classifier_unit
// scoreboard: weight mirror, class tallies and argmax verdicts kept alongside the block
`timescale 1ns / 100ps

module tb_binary_pixel_linear_classifier_unit;
	import bplc_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 40;
	localparam int          RANDOM_WORDS = 1000;
	localparam int          SAT_PIXELS = 1100;
	localparam longint      TALLY_MAX = 33554431;
	localparam longint      TALLY_MIN = -33554432;
	localparam logic        REQ_WEIGHT = 1'b0;
	localparam logic        REQ_PIXEL = 1'b1;

	// one word on the input channel, or a marker that waits for all verdicts
	typedef struct {
		bit                        drain;
		logic                      req;
		logic [FEATURE_IDX_W-1:0]  feat;
		logic [CLASS_IDX_W-1:0]    cls;
		logic [WEIGHT_IN_W-1:0]    wv;
		logic [PIXEL_W-1:0]        pix;
		logic [LABEL_W-1:0]        label;
		logic                      last;
	} pending_word_t;

	typedef struct {
		logic [CLASS_IDX_W-1:0]    cls;
		logic signed [SUM_W-1:0]   score;
		logic                      miss;
		logic [ERR_W-1:0]          errs;
	} verdict_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic                              req_type = 1'b0;
	logic [FEATURE_IDX_W-1:0]          feature_index = '0;
	logic [CLASS_IDX_W-1:0]            class_index = '0;
	logic signed [WEIGHT_IN_W-1:0]     weight_value = '0;
	logic [PIXEL_W-1:0]                pixel_value = '0;
	logic [LABEL_W-1:0]                true_label = '0;
	logic                              last_pixel = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [CLASS_IDX_W-1:0]            predicted_class;
	logic signed [SUM_W-1:0]           best_score;
	logic                              mismatch;
	logic [ERR_W-1:0]                  error_count;

	binary_pixel_linear_classifier_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.feature_index   (feature_index),
		.class_index     (class_index),
		.weight_value    (weight_value),
		.pixel_value     (pixel_value),
		.true_label      (true_label),
		.last_pixel      (last_pixel),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.predicted_class (predicted_class),
		.best_score      (best_score),
		.mismatch        (mismatch),
		.error_count     (error_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// free-running cycle count, also opens a window without random idle gaps
	int unsigned cycle_count = 0;
	logic        steady;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end
	assign steady = (cycle_count >= 1000) && (cycle_count < 2000);

	// ---------------------------------------------------------------
	// scoreboard state: mirror of the weight store and the tallies
	// ---------------------------------------------------------------
	weight_t     weight_mirror [NUM_FEATURES*NUM_CLASSES];
	longint      class_tally [NUM_CLASSES];
	logic [ERR_W-1:0] miss_tally = '0;
	verdict_t    expected_verdicts [$];
	int          verdicts_due = 0;
	int          verdicts_seen = 0;
	int          words_taken = 0;
	int          flagged_misses = 0;
	int          fail_count = 0;

	initial begin
		foreach (class_tally[k]) class_tally[k] = 0;
	end

	// apply one accepted word to the mirror; a last pixel yields one verdict
	task automatic classify_word(input pending_word_t wd);
		longint   sum;
		longint   top;
		int       winner;
		verdict_t v;
		if (wd.req == REQ_WEIGHT) begin
			// out of range writes fall on the floor, last mark means nothing here
			if (wd.feat < NUM_FEATURES && wd.cls < NUM_CLASSES)
				weight_mirror[wd.feat*NUM_CLASSES + wd.cls] = weight_t'(wd.wv);
			return;
		end
		// binarize: any nonzero intensity adds the whole row
		if (wd.pix != 0 && wd.feat < NUM_FEATURES) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				sum = class_tally[k] + weight_mirror[wd.feat*NUM_CLASSES + k];
				if (sum > TALLY_MAX) sum = TALLY_MAX;
				if (sum < TALLY_MIN) sum = TALLY_MIN;
				class_tally[k] = sum;
			end
		end
		if (!wd.last)
			return;
		// strict compare keeps the lowest index on ties
		winner = 0;
		top = class_tally[0];
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (class_tally[k] > top) begin
				top = class_tally[k];
				winner = k;
			end
		end
		v.cls = CLASS_IDX_W'(winner);
		v.score = SUM_W'(top);
		v.miss = (int'(wd.label) != winner);
		if (v.miss && miss_tally != '1)
			miss_tally++;
		v.errs = miss_tally;
		expected_verdicts.push_back(v);
		verdicts_due++;
		foreach (class_tally[k]) class_tally[k] = 0;
	endtask

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// ---------------------------------------------------------------
	// stimulus queue, filled before reset is released
	// ---------------------------------------------------------------
	pending_word_t pending_words [$];
	bit            entry_seen [NUM_FEATURES*NUM_CLASSES];
	int            row_entries [NUM_FEATURES];
	int            filled_rows [$];
	int            stim_words = 0;

	// weight write; tracks which rows are complete so pixels never read holes
	task automatic push_weight(input int feat, input int cls, input int wv, input bit last);
		pending_word_t w;
		w.drain = 1'b0;
		w.req = REQ_WEIGHT;
		w.feat = FEATURE_IDX_W'(feat);
		w.cls = CLASS_IDX_W'(cls);
		w.wv = WEIGHT_IN_W'(wv);
		w.pix = PIXEL_W'($urandom);
		w.label = LABEL_W'($urandom);
		w.last = last;
		pending_words.push_back(w);
		stim_words++;
		if (feat < NUM_FEATURES && cls < NUM_CLASSES && !entry_seen[feat*NUM_CLASSES + cls]) begin
			entry_seen[feat*NUM_CLASSES + cls] = 1'b1;
			row_entries[feat]++;
			if (row_entries[feat] == NUM_CLASSES)
				filled_rows.push_back(feat);
		end
	endtask

	task automatic push_pixel(input int feat, input int pix, input int label, input bit last);
		pending_word_t w;
		w.drain = 1'b0;
		w.req = REQ_PIXEL;
		w.feat = FEATURE_IDX_W'(feat);
		w.cls = CLASS_IDX_W'($urandom);
		w.wv = WEIGHT_IN_W'($urandom);
		w.pix = PIXEL_W'(pix);
		w.label = LABEL_W'(label);
		w.last = last;
		pending_words.push_back(w);
		stim_words++;
	endtask

	// sender waits here until every verdict so far has come back
	task automatic push_drain_point();
		pending_word_t w;
		w = '{default: '0};
		w.drain = 1'b1;
		pending_words.push_back(w);
	endtask

	// set pixels only hit complete rows; zero pixels and stray indexes go anywhere
	task automatic push_random_pixel(input int label, input bit last);
		int pick;
		pick = $urandom_range(99);
		if (pick < 75)
			push_pixel(filled_rows[$urandom_range(filled_rows.size() - 1)],
				$urandom_range(255, 1), label, last);
		else if (pick < 90)
			push_pixel($urandom_range(1023), 0, label, last);
		else
			push_pixel($urandom_range(1023, NUM_FEATURES), $urandom_range(255, 1), label, last);
	endtask

	// one row of extremes hit often enough that every class sum clips
	task automatic saturate_sample(input int row, input int hi);
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (c == hi)
				push_weight(row, c, 32767, $urandom_range(1));
			else if (c == (hi + 3) % NUM_CLASSES)
				push_weight(row, c, 32000, $urandom_range(1));
			else
				push_weight(row, c, -32768, $urandom_range(1));
		end
		for (int i = 0; i < SAT_PIXELS; i++)
			push_pixel(row, $urandom_range(255, 1), $urandom_range(15), 1'b0);
		push_pixel(row, $urandom_range(255, 1), hi, 1'b1);
	endtask

	// ---------------------------------------------------------------
	// input driver: one word per handshake, random gaps
	// ---------------------------------------------------------------
	pending_word_t on_port;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				classify_word(on_port);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				// drain markers release only once the block has caught up
				while (pending_words.size() != 0 && pending_words[0].drain
					&& verdicts_due == verdicts_seen)
					pending_words.delete(0);
				if (pending_words.size() == 0 || pending_words[0].drain
					|| (!steady && $urandom_range(99) < 33)) begin
					in_valid <= 1'b0;
				end else begin
					on_port = pending_words.pop_front();
					in_valid <= 1'b1;
					req_type <= on_port.req;
					feature_index <= on_port.feat;
					class_index <= on_port.cls;
					weight_value <= on_port.wv;
					pixel_value <= on_port.pix;
					true_label <= on_port.label;
					last_pixel <= on_port.last;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor and ready generator
	// ---------------------------------------------------------------
	int       hold_left = 0;
	bit       start_hold;
	verdict_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			verdicts_seen <= 0;
		end else begin
			start_hold = 1'b0;
			if (out_valid && out_ready) begin
				if (mismatch)
					flagged_misses++;
				if (expected_verdicts.size() == 0) begin
					log_failure($sformatf("unexpected verdict class %0d score %0d",
						predicted_class, best_score));
				end else begin
					want = expected_verdicts.pop_front();
					if (predicted_class !== want.cls || best_score !== want.score
						|| mismatch !== want.miss || error_count !== want.errs)
						log_failure($sformatf(
							"class %0d/%0d score %0d/%0d miss %0d/%0d errors %0d/%0d (exp/act)",
							want.cls, predicted_class, want.score, best_score,
							want.miss, mismatch, want.errs, error_count));
				end
				verdicts_seen <= verdicts_seen + 1;
				// long back-pressure so the block fills up and stalls its input
				start_hold = (verdicts_seen + 1 == 20) || (verdicts_seen + 1 == 150);
			end
			if (start_hold)
				hold_left <= HOLD_CYCLES;
			else if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_ready <= (hold_left == 0) && !start_hold
				&& (steady || $urandom_range(99) >= 33);
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus: directed words first, then random sequences
	// ---------------------------------------------------------------
	int pick;
	int row;
	int style;
	int span;
	int fill_val;
	bit sat_low_done = 1'b0;

	initial begin
		foreach (row_entries[f]) row_entries[f] = 0;

		// first and last rows, extreme and tied weights
		push_weight(0, 0, 32767, 1'b0);
		push_weight(0, 1, -32768, 1'b1);
		push_weight(0, 2, 0, 1'b0);
		push_weight(0, 3, 1, 1'b1);
		push_weight(0, 4, -1, 1'b0);
		push_weight(0, 5, 256, 1'b1);
		push_weight(0, 6, -256, 1'b0);
		push_weight(0, 7, 32767, 1'b1);
		push_weight(0, 8, 12345, 1'b0);
		push_weight(0, 9, -12345, 1'b1);
		push_weight(783, 0, -1, 1'b0);
		push_weight(783, 1, 2, 1'b0);
		push_weight(783, 2, -32768, 1'b1);
		push_weight(783, 3, 32767, 1'b0);
		push_weight(783, 4, 100, 1'b0);
		push_weight(783, 5, -100, 1'b1);
		push_weight(783, 6, 7, 1'b0);
		push_weight(783, 7, 7, 1'b0);
		push_weight(783, 8, 0, 1'b1);
		push_weight(783, 9, 32767, 1'b0);
		// writes outside the store are dropped, even when marked last
		push_weight(784, 3, 16'h5555, 1'b0);
		push_weight(1023, 15, 16'hAAAA, 1'b1);
		push_weight(5, 10, 32767, 1'b1);
		// sample with a stray pixel index and a label outside the classes
		push_pixel(0, 1, 0, 1'b0);
		push_pixel(783, 255, 0, 1'b0);
		push_pixel(1000, 128, 0, 1'b0);
		push_pixel(783, 0, 15, 1'b1);
		// all-zero tallies: tie across every class, lowest wins
		push_pixel(0, 0, 0, 1'b1);
		// a last pixel out of range still closes the sample
		push_pixel(1023, 255, 9, 1'b1);
		push_drain_point();

		stim_words = 0;
		while (stim_words < RANDOM_WORDS) begin
			// one sample clips high and low at once, with a tie at the top limit
			if (!sat_low_done && stim_words >= 300) begin
				push_drain_point();
				saturate_sample(1 + $urandom_range(NUM_FEATURES - 3), 7);
				sat_low_done = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 12) begin
				// complete row: equal, extreme or random weights
				row = $urandom_range(NUM_FEATURES - 1);
				style = $urandom_range(3);
				fill_val = $urandom_range(65535);
				for (int c = 0; c < NUM_CLASSES; c++) begin
					if (style == 1)
						fill_val = $urandom_range(1) ? 32767 : -32768;
					else if (style > 1)
						fill_val = $urandom_range(65535);
					push_weight(row, c, fill_val, $urandom_range(1));
				end
			end else if (pick < 20) begin
				push_weight($urandom_range(1023), $urandom_range(15), $urandom_range(65535),
					$urandom_range(1));
			end else if (pick < 25) begin
				// noise words that leave the tallies alone
				if ($urandom_range(1))
					push_pixel($urandom_range(1023), 0, $urandom_range(15), 1'b0);
				else
					push_weight($urandom_range(1023, NUM_FEATURES), $urandom_range(15),
						$urandom_range(65535), $urandom_range(1));
			end else begin
				span = $urandom_range(11);
				for (int i = 0; i < span; i++)
					push_random_pixel($urandom_range(15), 1'b0);
				push_random_pixel(($urandom_range(99) < 85) ? $urandom_range(9)
					: $urandom_range(15, NUM_CLASSES), 1'b1);
			end
			if ((stim_words % 150) < 8 && $urandom_range(3) == 0)
				push_drain_point();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid) @(posedge clk);
		while (verdicts_seen != verdicts_due) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_verdicts.size() != 0)
			log_failure($sformatf("%0d verdicts never arrived", expected_verdicts.size()));

		$display("run covered %0d words (weight writes and pixels) and %0d checked verdicts,",
			words_taken, verdicts_seen);
		$display("%0d of them flagged as mispredicted, including clipped tallies and ties",
			flagged_misses);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bplc_pkg.sv
rtl/core/bplc_front.sv
rtl/core/bplc_queue.sv
rtl/core/bplc_back.sv
rtl/core/binary_pixel_linear_classifier_unit.sv
tb/tb_binary_pixel_linear_classifier_unit.sv
